// ===== src/gmaze_pkg.sv =====
`timescale 1ns / 1ps
package gmaze_pkg;
    localparam int MAX_COLS_DEF = 32;
    localparam int MAX_ROWS_DEF = 32;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_BEGIN = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam logic [2:0] EV_ACK    = 3'd0;
    localparam logic [2:0] EV_EXTEND = 3'd1;
    localparam logic [2:0] EV_BACKUP = 3'd2;
    localparam logic [2:0] EV_FOUND  = 3'd3;
    localparam logic [2:0] EV_NOPATH = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCOL   = 3'd2;
    localparam logic [2:0] REG_SROW   = 3'd3;
    localparam logic [2:0] REG_GCOL   = 3'd4;
    localparam logic [2:0] REG_GROW   = 3'd5;
endpackage

// ===== src/grid_maze_dfs_stepper_core.sv =====
`timescale 1ns / 1ps
// Depth-first maze stepper.
// Command channel: drive action/cell_col/cell_row/wall_bits with start high;
// the command is taken at an edge where busy is low. Exactly one result per
// command appears on event_res/move_dir/path_length with done high for one
// cycle; the receiver cannot stall it.
// Load, begin and unused commands pass through a decode and a response state;
// a step adds a read and a check state per probed neighbor (up to 4 probes),
// then a stack read and a pop state on a back-up, or the read alone on
// no_path. Walls, visited marks and the move stack sit in single-port
// synchronous RAMs. A new command is taken in the cycle done is high.
// The visited map holds an epoch mark per cell, so a begin bumps the epoch
// and marks the start cell instead of clearing the map; the begin that wraps
// the epoch (once in 255) first sweeps every map entry back to zero.
// After reset the same sweep runs before the first command is taken; busy is
// high meanwhile, and APB writes are accepted throughout.
// Registers at byte addresses 4*i: width, height, start col/row, goal col/row.
module grid_maze_dfs_stepper_core #(
    parameter int MAX_COLS = gmaze_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = gmaze_pkg::MAX_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [4:0]  cell_col,
    input  logic [4:0]  cell_row,
    input  logic [3:0]  wall_bits,
    output logic        done,
    output logic [2:0]  event_res,
    output logic [1:0]  move_dir,
    output logic [10:0] path_length
);
    localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AB = CB + RB;
    localparam int CELLS = MAX_COLS * MAX_ROWS;
    localparam int MEM_DEPTH = 1 << AB;
    localparam int EB = 8;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_PROBE_RD, S_PROBE_CHK, S_POP_RD,
        S_POP_DO, S_RESP
    } state_t;

    // config registers
    logic [5:0] mw_reg, mh_reg;
    logic [4:0] scol_reg, srow_reg, gcol_reg, grow_reg;
    logic       cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mw_reg <= 6'd32; mh_reg <= 6'd32;
            scol_reg <= 5'd0; srow_reg <= 5'd0;
            gcol_reg <= 5'd31; grow_reg <= 5'd31;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                gmaze_pkg::REG_WIDTH:  mw_reg <= pwdata[5:0];
                gmaze_pkg::REG_HEIGHT: mh_reg <= pwdata[5:0];
                gmaze_pkg::REG_SCOL:   scol_reg <= pwdata[4:0];
                gmaze_pkg::REG_SROW:   srow_reg <= pwdata[4:0];
                gmaze_pkg::REG_GCOL:   gcol_reg <= pwdata[4:0];
                gmaze_pkg::REG_GROW:   grow_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[4:2])
            gmaze_pkg::REG_WIDTH:  prdata = {26'd0, mw_reg};
            gmaze_pkg::REG_HEIGHT: prdata = {26'd0, mh_reg};
            gmaze_pkg::REG_SCOL:   prdata = {27'd0, scol_reg};
            gmaze_pkg::REG_SROW:   prdata = {27'd0, srow_reg};
            gmaze_pkg::REG_GCOL:   prdata = {27'd0, gcol_reg};
            gmaze_pkg::REG_GROW:   prdata = {27'd0, grow_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // effective sizes (9 bits hold up to 511)
    logic [8:0] w_eff, h_eff;
    always_comb
    begin
        if (mw_reg == 6'd0) w_eff = 9'd1;
        else if ({3'd0, mw_reg} > 9'(MAX_COLS)) w_eff = 9'(MAX_COLS);
        else w_eff = {3'd0, mw_reg};
        if (mh_reg == 6'd0) h_eff = 9'd1;
        else if ({3'd0, mh_reg} > 9'(MAX_ROWS)) h_eff = 9'(MAX_ROWS);
        else h_eff = {3'd0, mh_reg};
    end

    // memories
    logic [3:0]    wall_mem [MEM_DEPTH];
    logic [EB-1:0] vis_mem  [MEM_DEPTH];
    logic [4:0]    stk_mem  [CELLS];
    logic [3:0]    wall_q;
    logic [EB-1:0] vis_q;
    logic [4:0]    stk_q;
    logic          wall_we, vis_we, stk_we;
    logic [AB-1:0] wall_a, vis_a, stk_a;
    logic [3:0]    wall_d;
    logic [EB-1:0] vis_d;
    logic [4:0]    stk_d;

    always_ff @(posedge clk)
    begin
        if (wall_we) wall_mem[wall_a] <= wall_d;
        wall_q <= wall_mem[wall_a];
    end
    always_ff @(posedge clk)
    begin
        if (vis_we) vis_mem[vis_a] <= vis_d;
        vis_q <= vis_mem[vis_a];
    end
    always_ff @(posedge clk)
    begin
        if (stk_we) stk_mem[stk_a] <= stk_d;
        stk_q <= stk_mem[stk_a];
    end

    state_t        state_reg;
    logic [AB:0]   clr_reg;
    logic [EB-1:0] epoch_reg;
    logic [1:0]    act_reg;
    logic [4:0]    icol_reg, irow_reg;
    logic [3:0]    iwall_reg;
    logic [CB-1:0] wc_reg;
    logic [RB-1:0] wr_reg;
    logic [2:0]    try_reg;
    logic [10:0]   depth_reg;
    logic [1:0]    stat_reg;
    logic [3:0]    cw_reg;
    logic [CB-1:0] nc_reg;
    logic [RB-1:0] nr_reg;
    logic          nok_reg;
    logic          done_reg;
    logic [2:0]    ev_reg;
    logic [1:0]    dir_reg;
    logic [10:0]   len_reg;

    localparam logic [1:0] ST_IDLE = 2'd0, ST_SEARCH = 2'd1,
                           ST_FOUND = 2'd2, ST_NOPATH = 2'd3;

    // candidate neighbor for direction try_reg[1:0]
    logic [8:0] cc, cr, ncw, nrw;
    logic       cand_ok;
    always_comb
    begin
        cc = 9'(wc_reg);
        cr = 9'(wr_reg);
        ncw = cc; nrw = cr; cand_ok = 1'b1;
        unique case (try_reg[1:0])
            gmaze_pkg::DIR_UP:    if (cr == 9'd0) cand_ok = 1'b0; else nrw = cr - 9'd1;
            gmaze_pkg::DIR_DOWN:  nrw = cr + 9'd1;
            gmaze_pkg::DIR_RIGHT: ncw = cc + 9'd1;
            gmaze_pkg::DIR_LEFT:  if (cc == 9'd0) cand_ok = 1'b0; else ncw = cc - 9'd1;
            default: ;
        endcase
        if (ncw >= w_eff || nrw >= h_eff) cand_ok = 1'b0;
        if (cw_reg[try_reg[1:0]]) cand_ok = 1'b0;
    end

    logic at_goal_cur, at_goal_nb;
    assign at_goal_cur = (5'(wc_reg) == gcol_reg) && (9'(wc_reg) < 9'd32) &&
                         (5'(wr_reg) == grow_reg) && (9'(wr_reg) < 9'd32);
    assign at_goal_nb  = (9'(nc_reg) == {4'd0, gcol_reg}) &&
                         (9'(nr_reg) == {4'd0, grow_reg});

    logic [CB-1:0] s_col;
    logic [RB-1:0] s_row;
    always_comb
    begin
        s_col = ({4'd0, scol_reg} < w_eff) ? CB'(scol_reg) : CB'(w_eff - 9'd1);
        s_row = ({4'd0, srow_reg} < h_eff) ? RB'(srow_reg) : RB'(h_eff - 9'd1);
    end

    logic cell_in;
    assign cell_in = ({4'd0, icol_reg} < 9'(MAX_COLS)) && ({4'd0, irow_reg} < 9'(MAX_ROWS));

    // memory port control
    always_comb
    begin
        wall_we = 1'b0; vis_we = 1'b0; stk_we = 1'b0;
        wall_a = {wr_reg, wc_reg};
        vis_a  = {nr_reg, nc_reg};
        stk_a  = AB'(depth_reg - 11'd1);
        wall_d = iwall_reg;
        vis_d  = epoch_reg;
        stk_d  = {try_reg + 3'd1, try_reg[1:0]};
        unique case (state_reg)
            S_CLEAR:
            begin
                // zero is never a live epoch
                vis_we = 1'b1;
                vis_a = clr_reg[AB-1:0];
                vis_d = '0;
            end
            S_DECODE:
            begin
                if (act_reg == gmaze_pkg::ACT_LOAD && cell_in)
                begin
                    wall_we = 1'b1;
                    wall_a = {RB'(irow_reg), CB'(icol_reg)};
                end
                else if (act_reg == gmaze_pkg::ACT_BEGIN && epoch_reg != {EB{1'b1}})
                begin
                    vis_we = 1'b1;
                    vis_a = {s_row, s_col};
                    vis_d = epoch_reg + EB'(1);
                end
            end
            S_PROBE_RD:
                vis_a = {RB'(nrw), CB'(ncw)};
            S_PROBE_CHK:
            begin
                if (nok_reg && vis_q != epoch_reg && depth_reg < 11'(CELLS))
                begin
                    vis_we = 1'b1;
                    stk_we = 1'b1;
                    stk_a = AB'(depth_reg);
                end
            end
            default: ;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign event_res = ev_reg;
    assign move_dir = dir_reg;
    assign path_length = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            epoch_reg <= '0;
            wc_reg <= '0; wr_reg <= '0;
            try_reg <= 3'd0; depth_reg <= 11'd0;
            stat_reg <= ST_IDLE;
            done_reg <= 1'b0;
            ev_reg <= gmaze_pkg::EV_ACK; dir_reg <= 2'd0; len_reg <= 11'd0;
            act_reg <= gmaze_pkg::ACT_LOAD;
            icol_reg <= 5'd0; irow_reg <= 5'd0; iwall_reg <= 4'd0;
            cw_reg <= 4'd0;
            nc_reg <= '0; nr_reg <= '0;
            nok_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + (AB+1)'(1);
                    if (clr_reg == (AB+1)'(MEM_DEPTH - 1))
                    begin
                        clr_reg <= '0;
                        // a wrapping begin resumes once the map is swept
                        state_reg <= (act_reg == gmaze_pkg::ACT_BEGIN) ? S_DECODE : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        act_reg <= action;
                        icol_reg <= cell_col; irow_reg <= cell_row;
                        iwall_reg <= wall_bits;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    ev_reg <= gmaze_pkg::EV_ACK; dir_reg <= 2'd0;
                    len_reg <= depth_reg;
                    state_reg <= S_RESP;
                    if (act_reg == gmaze_pkg::ACT_BEGIN)
                    begin
                        wc_reg <= s_col; wr_reg <= s_row;
                        try_reg <= 3'd0; depth_reg <= 11'd0;
                        len_reg <= 11'd0;
                        stat_reg <= ST_SEARCH;
                        // epoch wrap: sweep the map back to the stale mark first
                        if (epoch_reg == {EB{1'b1}})
                        begin
                            epoch_reg <= '0;
                            state_reg <= S_CLEAR;
                        end
                        else
                            epoch_reg <= epoch_reg + EB'(1);
                    end
                    else if (act_reg == gmaze_pkg::ACT_STEP)
                    begin
                        unique case (stat_reg)
                            ST_IDLE: ;
                            ST_FOUND: ev_reg <= gmaze_pkg::EV_FOUND;
                            ST_NOPATH: ev_reg <= gmaze_pkg::EV_NOPATH;
                            default:
                            begin
                                if (at_goal_cur)
                                begin
                                    stat_reg <= ST_FOUND;
                                    ev_reg <= gmaze_pkg::EV_FOUND;
                                end
                                else
                                begin
                                    cw_reg <= wall_q;
                                    state_reg <= (try_reg[2]) ? S_POP_RD : S_PROBE_RD;
                                end
                            end
                        endcase
                    end
                end
                S_PROBE_RD:
                begin
                    nc_reg <= CB'(ncw); nr_reg <= RB'(nrw);
                    nok_reg <= cand_ok;
                    state_reg <= S_PROBE_CHK;
                end
                S_PROBE_CHK:
                begin
                    if (nok_reg && vis_q != epoch_reg && depth_reg < 11'(CELLS))
                    begin
                        depth_reg <= depth_reg + 11'd1;
                        len_reg <= depth_reg + 11'd1;
                        wc_reg <= nc_reg; wr_reg <= nr_reg;
                        try_reg <= 3'd0;
                        dir_reg <= try_reg[1:0];
                        if (at_goal_nb)
                        begin
                            stat_reg <= ST_FOUND;
                            ev_reg <= gmaze_pkg::EV_FOUND;
                        end
                        else
                            ev_reg <= gmaze_pkg::EV_EXTEND;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        try_reg <= try_reg + 3'd1;
                        state_reg <= (try_reg == 3'd3) ? S_POP_RD : S_PROBE_RD;
                    end
                end
                S_POP_RD:
                begin
                    if (depth_reg == 11'd0)
                    begin
                        stat_reg <= ST_NOPATH;
                        ev_reg <= gmaze_pkg::EV_NOPATH;
                        len_reg <= 11'd0;
                        state_reg <= S_RESP;
                    end
                    else
                        state_reg <= S_POP_DO;
                end
                S_POP_DO:
                begin
                    depth_reg <= depth_reg - 11'd1;
                    len_reg <= depth_reg - 11'd1;
                    try_reg <= stk_q[4:2];
                    dir_reg <= stk_q[1:0];
                    ev_reg <= gmaze_pkg::EV_BACKUP;
                    unique case (stk_q[1:0])
                        gmaze_pkg::DIR_UP:    wr_reg <= wr_reg + RB'(1);
                        gmaze_pkg::DIR_DOWN:  wr_reg <= wr_reg - RB'(1);
                        gmaze_pkg::DIR_RIGHT: wc_reg <= wc_reg - CB'(1);
                        default:              wc_reg <= wc_reg + CB'(1);
                    endcase
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/maze_walk_checker.sv =====
`timescale 1ns / 1ps
module maze_walk_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [4:0]  cell_col,
    input  logic [4:0]  cell_row,
    input  logic [3:0]  wall_bits,
    input  logic        done,
    input  logic [2:0]  event_res,
    input  logic [1:0]  move_dir,
    input  logic [10:0] path_length,
    output int          mismatches,
    output int          pending
);
    localparam int NCELLS = gmaze_pkg::MAX_COLS_DEF * gmaze_pkg::MAX_ROWS_DEF;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FOUND, S_NOPATH} search_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [1:0]  dir;
        logic [10:0] len;
    } walk_result_t;

    walk_result_t result_q[$];

    logic [5:0] cols_cfg, rows_cfg;
    logic [4:0] scol_cfg, srow_cfg, gcol_cfg, grow_cfg;

    logic [3:0] walls[NCELLS];
    bit         seen[NCELLS];
    logic [4:0] moves[NCELLS];
    int         wcol, wrow, try_dir, depth;
    search_t    status;

    function automatic int clamp_size(logic [5:0] v, int cap);
        if (v == 0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    function automatic walk_result_t pack_res(logic [2:0] ev, int d);
        walk_result_t r;
        r.ev  = ev;
        r.dir = d[1:0];
        r.len = depth[10:0];
        return r;
    endfunction

    function automatic walk_result_t predict_walk(logic [1:0] act, logic [4:0] c, logic [4:0] r,
                                                  logic [3:0] wb);
        int w, h, d, nc, nr, e;
        bit ok;
        w = clamp_size(cols_cfg, gmaze_pkg::MAX_COLS_DEF);
        h = clamp_size(rows_cfg, gmaze_pkg::MAX_ROWS_DEF);
        if (act == gmaze_pkg::ACT_LOAD) begin
            walls[r * gmaze_pkg::MAX_COLS_DEF + c] = wb;
            return pack_res(gmaze_pkg::EV_ACK, gmaze_pkg::DIR_UP);
        end
        if (act == gmaze_pkg::ACT_BEGIN) begin
            foreach (seen[i]) seen[i] = 0;
            wcol = (scol_cfg < w) ? scol_cfg : w - 1;
            wrow = (srow_cfg < h) ? srow_cfg : h - 1;
            seen[wrow * gmaze_pkg::MAX_COLS_DEF + wcol] = 1;
            try_dir = 0;
            depth = 0;
            status = S_SEARCH;
            return pack_res(gmaze_pkg::EV_ACK, gmaze_pkg::DIR_UP);
        end
        if (act != gmaze_pkg::ACT_STEP || status == S_IDLE)
            return pack_res(gmaze_pkg::EV_ACK, gmaze_pkg::DIR_UP);
        if (status == S_FOUND) return pack_res(gmaze_pkg::EV_FOUND, gmaze_pkg::DIR_UP);
        if (status == S_NOPATH) return pack_res(gmaze_pkg::EV_NOPATH, gmaze_pkg::DIR_UP);
        if (wcol == gcol_cfg && wrow == grow_cfg) begin
            status = S_FOUND;
            return pack_res(gmaze_pkg::EV_FOUND, gmaze_pkg::DIR_UP);
        end
        while (try_dir < 4) begin
            d = try_dir;
            nc = wcol;
            nr = wrow;
            ok = 1;
            try_dir++;
            if (walls[wrow * gmaze_pkg::MAX_COLS_DEF + wcol][d]) continue;
            case (d)
                gmaze_pkg::DIR_UP:    if (nr == 0) ok = 0; else nr--;
                gmaze_pkg::DIR_DOWN:  nr++;
                gmaze_pkg::DIR_RIGHT: nc++;
                default:              if (nc == 0) ok = 0; else nc--;
            endcase
            if (!ok || nc >= w || nr >= h) continue;
            if (seen[nr * gmaze_pkg::MAX_COLS_DEF + nc]) continue;
            if (depth >= NCELLS) continue;
            moves[depth] = 5'(d | (try_dir << 2));
            depth++;
            wcol = nc;
            wrow = nr;
            seen[nr * gmaze_pkg::MAX_COLS_DEF + nc] = 1;
            try_dir = 0;
            if (nc == gcol_cfg && nr == grow_cfg) begin
                status = S_FOUND;
                return pack_res(gmaze_pkg::EV_FOUND, d);
            end
            return pack_res(gmaze_pkg::EV_EXTEND, d);
        end
        if (depth == 0) begin
            status = S_NOPATH;
            return pack_res(gmaze_pkg::EV_NOPATH, gmaze_pkg::DIR_UP);
        end
        depth--;
        e = moves[depth % NCELLS];
        d = e & 3;
        try_dir = (e >> 2) & 7;
        case (d)
            gmaze_pkg::DIR_UP:    wrow++;
            gmaze_pkg::DIR_DOWN:  if (wrow > 0) wrow--;
            gmaze_pkg::DIR_RIGHT: if (wcol > 0) wcol--;
            default:              wcol++;
        endcase
        if (wcol >= gmaze_pkg::MAX_COLS_DEF) wcol = gmaze_pkg::MAX_COLS_DEF - 1;
        if (wrow >= gmaze_pkg::MAX_ROWS_DEF) wrow = gmaze_pkg::MAX_ROWS_DEF - 1;
        return pack_res(gmaze_pkg::EV_BACKUP, d);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t got, want;
        if (!rst_n) begin
            cols_cfg = 6'd32;
            rows_cfg = 6'd32;
            scol_cfg = 5'd0;
            srow_cfg = 5'd0;
            gcol_cfg = 5'd31;
            grow_cfg = 5'd31;
            foreach (seen[i]) seen[i] = 0;
            wcol = 0;
            wrow = 0;
            try_dir = 0;
            depth = 0;
            status = S_IDLE;
            result_q.delete();
            mismatches = 0;
            pending = 0;
        end else begin
            if (done) begin
                got = '{event_res, move_dir, path_length};
                if (result_q.size() == 0) begin
                    $error("result with no transaction outstanding: ev=%0d", event_res);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    if (got.ev !== want.ev) begin
                        $error("event_res expected %0d got %0d", want.ev, got.ev);
                        mismatches++;
                    end
                    if (got.dir !== want.dir) begin
                        $error("move_dir expected %0d got %0d", want.dir, got.dir);
                        mismatches++;
                    end
                    if (got.len !== want.len) begin
                        $error("path_length expected %0d got %0d", want.len, got.len);
                        mismatches++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    gmaze_pkg::REG_WIDTH:  cols_cfg = pwdata[5:0];
                    gmaze_pkg::REG_HEIGHT: rows_cfg = pwdata[5:0];
                    gmaze_pkg::REG_SCOL:   scol_cfg = pwdata[4:0];
                    gmaze_pkg::REG_SROW:   srow_cfg = pwdata[4:0];
                    gmaze_pkg::REG_GCOL:   gcol_cfg = pwdata[4:0];
                    gmaze_pkg::REG_GROW:   grow_cfg = pwdata[4:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                result_q.push_back(predict_walk(action, cell_col, cell_row, wall_bits));
            pending = result_q.size();
        end
    end
endmodule

// ===== tb/tb_grid_maze_dfs_stepper_core.sv =====
`timescale 1ns / 1ps
module tb_grid_maze_dfs_stepper_core;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1450;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 0;
    logic        busy;
    logic [1:0]  action = gmaze_pkg::ACT_LOAD;
    logic [4:0]  cell_col = '0, cell_row = '0;
    logic [3:0]  wall_bits = '0;
    logic        done;
    logic [2:0]  event_res;
    logic [1:0]  move_dir;
    logic [10:0] path_length;
    int          mismatches, pending;

    int cycles = 0;
    int sent = 0;
    int burst_left = 0;
    bit loaded[1024];

    always #4 clk = ~clk;

    grid_maze_dfs_stepper_core dut (.*);

    maze_walk_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send(logic [1:0] act, logic [4:0] c, logic [4:0] r, logic [3:0] wb);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                @(negedge clk);
                start = 0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start = 1;
        action = act;
        cell_col = c;
        cell_row = r;
        wall_bits = wb;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (act == gmaze_pkg::ACT_LOAD) loaded[r * 32 + c] = 1;
        sent++;
    endtask

    function automatic logic [3:0] rand_walls(int dens);
        logic [3:0] v;
        for (int b = 0; b < 4; b++) v[b] = ($urandom_range(0, 7) < dens);
        return v;
    endfunction

    function automatic int eff_size(int v);
        return (v == 0) ? 1 : ((v > 32) ? 32 : v);
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        start = 0;
        burst_left = 0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    // one configuration, walls for the area, then begin and a run of steps mixed with stray loads, spares and begins
    task automatic run_maze(int w, int h, int sc, int sr, int gc, int gr, int dens);
        int ew, eh, nsteps, k;
        wait_idle();
        apb_write(gmaze_pkg::REG_WIDTH, w);
        apb_write(gmaze_pkg::REG_HEIGHT, h);
        apb_write(gmaze_pkg::REG_SCOL, sc);
        apb_write(gmaze_pkg::REG_SROW, sr);
        apb_write(gmaze_pkg::REG_GCOL, gc);
        apb_write(gmaze_pkg::REG_GROW, gr);
        ew = eff_size(w);
        eh = eff_size(h);
        for (int r = 0; r < eh; r++)
            for (int c = 0; c < ew; c++)
                if (!loaded[r * 32 + c] || $urandom_range(0, 3) == 0)
                    send(gmaze_pkg::ACT_LOAD, 5'(c), 5'(r), rand_walls(dens));
        send(gmaze_pkg::ACT_BEGIN, 5'($urandom), 5'($urandom), 4'($urandom));
        nsteps = 2 * ew * eh + 4;
        if (nsteps > 300) nsteps = 300;
        for (int i = 0; i < nsteps; i++) begin
            k = $urandom_range(0, 19);
            if (k == 0)
                send(gmaze_pkg::ACT_LOAD, 5'($urandom), 5'($urandom), 4'($urandom));
            else if (k == 1)
                send(gmaze_pkg::ACT_SPARE, 5'($urandom), 5'($urandom), 4'($urandom));
            else if (k == 2 && i > nsteps / 2)
                send(gmaze_pkg::ACT_BEGIN, 5'($urandom), 5'($urandom), 4'($urandom));
            send(gmaze_pkg::ACT_STEP, 5'($urandom), 5'($urandom), 4'($urandom));
        end
    endtask

    initial
    begin
        int w, h;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // step while idle and unused action before anything is loaded
        send(gmaze_pkg::ACT_STEP, 5'd31, 5'd31, 4'hf);
        send(gmaze_pkg::ACT_SPARE, 5'd0, 5'd0, 4'h0);
        send(gmaze_pkg::ACT_LOAD, 5'd31, 5'd31, 4'hf);
        send(gmaze_pkg::ACT_LOAD, 5'd0, 5'd0, 4'h0);
        run_maze(2, 2, 0, 0, 1, 1, 0);
        run_maze(1, 1, 0, 0, 0, 0, 2);       // start equals goal
        run_maze(0, 0, 3, 3, 0, 0, 1);       // zero size, start saturates
        run_maze(5, 4, 31, 31, 3, 2, 2);     // start saturates to corner
        run_maze(4, 4, 0, 0, 31, 31, 1);     // goal outside: exhausts to no_path
        run_maze(63, 63, 31, 31, 0, 0, 1);   // size above the maximum
        while (sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(0, 63);
                h = $urandom_range(0, 63);
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 8);
            end
            run_maze(w, h,
                     $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 7),
                     $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 7),
                     $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 7),
                     $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 7),
                     $urandom_range(0, 4));
        end
        @(negedge clk);
        start = 0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/gmaze_pkg.sv
src/grid_maze_dfs_stepper_core.sv
tb/maze_walk_checker.sv
tb/tb_grid_maze_dfs_stepper_core.sv
